FILE: design/l2h_pkg.sv
package l2h_pkg;

   // Item codes carried in req_tuser
   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_START  = 2'd1,
      CMD_END    = 2'd2
   } command_type;

   localparam int          BIN_BITS   = 7;
   localparam int          COUNT_BITS = 31;
   localparam int          PAIR_BITS  = 6;
   localparam int          EVEN_DEPTH = 33;
   localparam int          ODD_DEPTH  = 32;
   localparam logic [PAIR_BITS-1:0]  LAST_PAIR = 6'd32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic        update;
      logic        set_active;
      logic [63:0] thread_id;
   } slot_req_type;

   typedef struct packed {
      logic                 en;
      logic [PAIR_BITS-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic                  en;
      logic [BIN_BITS-1:0]   bin;
      logic [COUNT_BITS-1:0] data;
   } mem_wr_type;

   // Number of significant bits: 0 for zero, up to 64
   function automatic logic [BIN_BITS-1:0] sig_bits(input logic [63:0] value);
      logic [BIN_BITS-1:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         if (value[i]) begin
            n = BIN_BITS'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

FILE: design/l2h_slot_table.sv
module l2h_slot_table #(
   parameter int ACTIVE_SLOTS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [63:0]           lookup_id,
   input  l2h_pkg::slot_req_type req,
   output logic                  active_hit
);
   import l2h_pkg::*;

   logic [63:0]             ids_ff [ACTIVE_SLOTS];
   logic [ACTIVE_SLOTS-1:0] used_ff;
   logic [ACTIVE_SLOTS-1:0] active_ff;
   logic [ACTIVE_SLOTS-1:0] match;
   logic [ACTIVE_SLOTS-1:0] upd_match;
   logic [ACTIVE_SLOTS-1:0] free;
   logic [ACTIVE_SLOTS-1:0] claim;

   always_comb begin
      for (int i = 0; i < ACTIVE_SLOTS; i++) begin
         match[i]     = used_ff[i] && (ids_ff[i] == lookup_id);
         upd_match[i] = used_ff[i] && (ids_ff[i] == req.thread_id);
      end
   end

   assign active_hit = |(match & active_ff);

   // lowest free slot, one-hot
   assign free  = ~used_ff;
   assign claim = free & (~free + ACTIVE_SLOTS'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         active_ff <= '0;
      end else if (req.update) begin
         if (|upd_match) begin
            for (int i = 0; i < ACTIVE_SLOTS; i++) begin
               if (upd_match[i]) begin
                  active_ff[i] <= req.set_active;
               end
            end
         end else begin
            // drop the update when no slot is free
            used_ff <= used_ff | claim;
            for (int i = 0; i < ACTIVE_SLOTS; i++) begin
               if (claim[i]) begin
                  active_ff[i] <= req.set_active;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.update && !(|upd_match)) begin
         for (int i = 0; i < ACTIVE_SLOTS; i++) begin
            if (claim[i]) begin
               ids_ff[i] <= req.thread_id;
            end
         end
      end
   end

endmodule

FILE: design/l2h_bin_mem.sv
module l2h_bin_mem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  l2h_pkg::mem_rd_type            rd,
   input  l2h_pkg::mem_wr_type            wr,
   output logic [l2h_pkg::COUNT_BITS-1:0] rd_even,
   output logic [l2h_pkg::COUNT_BITS-1:0] rd_odd
);
   import l2h_pkg::*;

   logic [COUNT_BITS-1:0] even_mem [EVEN_DEPTH];
   logic [COUNT_BITS-1:0] odd_mem  [ODD_DEPTH];
   logic [EVEN_DEPTH-1:0] even_vld_ff;
   logic [ODD_DEPTH-1:0]  odd_vld_ff;
   logic [COUNT_BITS-1:0] even_rd_ff;
   logic [COUNT_BITS-1:0] odd_rd_ff;
   logic                  even_ok_ff;
   logic                  odd_ok_ff;

   // even bank holds bins 0,2..64; odd bank bins 1,3..63
   always_ff @(posedge clock) begin
      if (wr.en && !wr.bin[0]) begin
         even_mem[wr.bin[6:1]] <= wr.data;
      end
      if (wr.en && wr.bin[0]) begin
         odd_mem[wr.bin[5:1]] <= wr.data;
      end
      if (rd.en) begin
         even_rd_ff <= even_mem[rd.addr];
         odd_rd_ff  <= odd_mem[rd.addr[4:0]];
         even_ok_ff <= even_vld_ff[rd.addr];
         odd_ok_ff  <= !rd.addr[5] && odd_vld_ff[rd.addr[4:0]];
      end
   end

   // clear beats a same-cycle write: the clearing item is younger
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         even_vld_ff <= '0;
         odd_vld_ff  <= '0;
      end else if (wr.en) begin
         if (wr.bin[0]) begin
            odd_vld_ff[wr.bin[5:1]] <= 1'b1;
         end else begin
            even_vld_ff[wr.bin[6:1]] <= 1'b1;
         end
      end
   end

   assign rd_even = even_ok_ff ? even_rd_ff : '0;
   assign rd_odd  = odd_ok_ff  ? odd_rd_ff  : '0;

endmodule

FILE: design/log2_size_histogram.sv
// Gated log2 histogram of request sizes. Each item on req carries a command in req_tuser
// (sample, start, end) and a thread id and size in req_tdata. A sample from a thread marked
// active in the slot table increments the bin for the size's significant bit count (0..64,
// saturating at 2^31-1) and adds the size to a wrapping 64-bit total. Start marks the thread
// active and clears all bins and the total; end marks it inactive and dumps 33 items on rsp,
// each with bins 2k and 2k+1 and the total, tlast on the final one. Bins live in two
// memory banks (even and odd bins) with registered reads and per-entry valid bits, so a
// clear takes effect at once with no sweep. Samples, starts and other commands are taken
// one per cycle while no dump is pending or running: a sample looks up its slot and reads
// its bin in one cycle and writes the incremented count back in the next, with back-to-back
// hits on one bin forwarded around the memory. An end item blocks req for the whole dump,
// with a bank read, then a load of the output register (held while rsp stalls), per item.
module log2_size_histogram #(
   parameter int ACTIVE_SLOTS = 8,
   parameter int VALUE_BITS   = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // thread_id[63:0], alloc_size[127:64]
   input  logic [1:0]   req_tuser,  // command[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,  // pair_index[5:0], count_even_bin[36:6],
                                    // count_odd_bin[67:37], total_bytes[131:68], zero pad
   output logic         rsp_tlast   // last
);
   import l2h_pkg::*;

   localparam logic [63:0] SIZE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   // lookup stage
   logic                  s1_vld_ff;
   logic [1:0]            s1_cmd_ff;
   logic [63:0]           s1_id_ff;
   logic [63:0]           s1_size_ff;
   logic                  s1_hit;
   logic [BIN_BITS-1:0]   s1_bin;
   logic                  active_hit;
   logic                  clear;
   logic                  dump_start;
   slot_req_type          slot_req;

   // write-back stage
   logic                  s2_hit_ff;
   logic [BIN_BITS-1:0]   s2_bin_ff;
   logic                  fwd_ff;
   logic                  fwd_in;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] new_count;

   logic [63:0]           total_ff;
   logic [63:0]           total_in;

   mem_rd_type            mem_rd;
   mem_wr_type            mem_wr;
   logic [COUNT_BITS-1:0] rd_even;
   logic [COUNT_BITS-1:0] rd_odd;

   // dump sequencer and output register
   state_type             state_ff;
   logic [PAIR_BITS-1:0]  pair_ff;
   logic                  rsp_vld_ff;
   logic [PAIR_BITS-1:0]  rsp_pair_ff;
   logic [COUNT_BITS-1:0] rsp_even_ff;
   logic [COUNT_BITS-1:0] rsp_odd_ff;
   logic [63:0]           rsp_total_ff;
   logic                  rsp_last_ff;

   // hold req while a dump is pending or running
   assign dump_start = s1_vld_ff && (s1_cmd_ff == CMD_END);
   assign req_tready = (state_ff == ST_IDLE) && !dump_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_tvalid && req_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff  <= req_tuser;
         s1_id_ff   <= req_tdata[63:0];
         s1_size_ff <= req_tdata[127:64] & SIZE_MASK;
      end
   end

   assign slot_req.update     = s1_vld_ff && ((s1_cmd_ff == CMD_START) || (s1_cmd_ff == CMD_END));
   assign slot_req.set_active = (s1_cmd_ff == CMD_START);
   assign slot_req.thread_id  = s1_id_ff;

   l2h_slot_table #(
      .ACTIVE_SLOTS(ACTIVE_SLOTS)
   ) u_slots (
      .clock     (clock),
      .reset     (reset),
      .lookup_id (s1_id_ff),
      .req       (slot_req),
      .active_hit(active_hit)
   );

   assign s1_hit = s1_vld_ff && (s1_cmd_ff == CMD_SAMPLE) && active_hit;
   assign s1_bin = sig_bits(s1_size_ff);
   assign clear  = s1_vld_ff && (s1_cmd_ff == CMD_START);

   // running total: start zeroes it, counted samples add
   always_comb begin
      total_in = total_ff;
      if (clear) begin
         total_in = '0;
      end else if (s1_hit) begin
         total_in = total_ff + s1_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // one read port shared by sample lookups and the dump
   assign mem_rd.en   = (state_ff == ST_READ) || s1_hit;
   assign mem_rd.addr = (state_ff == ST_READ) ? pair_ff : s1_bin[6:1];

   // forward when the next sample hits the bin being written back
   assign fwd_in = s1_hit && s2_hit_ff && (s1_bin == s2_bin_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_hit_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         s2_hit_ff <= s1_hit;
         fwd_ff    <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_bin_ff   <= s1_bin;
      fwd_data_ff <= new_count;
   end

   always_comb begin
      if (fwd_ff) begin
         cur_count = fwd_data_ff;
      end else if (s2_bin_ff[0]) begin
         cur_count = rd_odd;
      end else begin
         cur_count = rd_even;
      end
      // saturate at the top of the count range
      new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
   end

   assign mem_wr.en   = s2_hit_ff;
   assign mem_wr.bin  = s2_bin_ff;
   assign mem_wr.data = new_count;

   l2h_bin_mem u_bins (
      .clock  (clock),
      .reset  (reset),
      .clear  (clear),
      .rd     (mem_rd),
      .wr     (mem_wr),
      .rd_even(rd_even),
      .rd_odd (rd_odd)
   );

   // dump: read a bin pair, then load it into the output register when free
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pair_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rsp_vld_ff && rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (dump_start) begin
                  pair_ff  <= '0;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               if (!rsp_vld_ff || rsp_tready) begin
                  rsp_vld_ff   <= 1'b1;
                  rsp_pair_ff  <= pair_ff;
                  rsp_even_ff  <= rd_even;
                  rsp_odd_ff   <= rd_odd;
                  rsp_total_ff <= total_ff;
                  rsp_last_ff  <= (pair_ff == LAST_PAIR);
                  if (pair_ff == LAST_PAIR) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     pair_ff  <= pair_ff + PAIR_BITS'(1);
                     state_ff <= ST_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_total_ff, rsp_odd_ff, rsp_even_ff, rsp_pair_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: design/l2h_checker.sv
module l2h_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         rsp_tlast
);
   import l2h_pkg::*;

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // the final dump item is pair 32, whose odd bin does not exist
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[5:0] == LAST_PAIR) && (rsp_tdata[67:37] == '0))
      else $error("final dump item malformed");

   // an end item blocks req in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_END) |=> !req_tready)
      else $error("req taken right after an end item");

   // req stays blocked while a dump is still under way
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("req open during a dump");

endmodule

bind log2_size_histogram l2h_checker u_l2h_checker (.*);
